/* sv/css_pkg.sv */
// Shared constants and types of the cosine similarity stream.
// Sizes the accumulators from the vector length limit and defines the job
// that moves from the front part to the back part.
package css_pkg;

   localparam int unsigned MAX_LENGTH  = 131072;
   localparam int unsigned ELEM_W      = 16;
   localparam int unsigned PROD_W      = 2 * ELEM_W;
   localparam int unsigned SQ_PROD_W   = 2 * ELEM_W - 1;
   localparam int unsigned CNT_W       = $clog2(MAX_LENGTH + 2);
   localparam int unsigned SQ_W        = $clog2(MAX_LENGTH + 1) + SQ_PROD_W - 1;
   localparam int unsigned DOT_W       = SQ_W + 1;
   localparam int unsigned WIDE_W      = 2 * SQ_W;
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned QUO_W       = 2 * FRAC_W + 1;
   localparam int unsigned ROOT_W      = QUO_W + 1;
   localparam int unsigned ROOT_STEPS  = FRAC_W + 1;
   localparam int unsigned SIM_W       = FRAC_W + 2;
   localparam int unsigned STEPS_MAX   = (SQ_W > QUO_W) ? SQ_W : QUO_W;
   localparam int unsigned STEP_W      = $clog2(STEPS_MAX);
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_NORM = 2'd1,
      STATUS_TOO_LONG  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] dot;
      logic [SQ_W-1:0]         sum_a;
      logic [SQ_W-1:0]         sum_b;
      status_type              status;
   } job_type;

endpackage

/* sv/css_front.sv */
// Front part of the cosine similarity stream: takes element pairs,
// multiplies and accumulates them, and emits one job per vector.
// Depends on css_pkg.
module css_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [css_pkg::ELEM_W-1:0]  req_src_value,
   input  logic signed [css_pkg::ELEM_W-1:0]  req_dst_value,
   input  logic                               req_last_element,
   output logic                               job_push,
   output css_pkg::job_type                   job_data,
   input  logic                               job_full
);

   logic                                 stage_valid_ff, stage_valid_in;
   logic                                 stage_last_ff;
   logic signed [css_pkg::PROD_W-1:0]    pd_ff;
   logic [css_pkg::SQ_PROD_W-1:0]        pa_ff, pb_ff;
   logic signed [css_pkg::DOT_W-1:0]     dot_ff, dot_in, dot_new;
   logic [css_pkg::SQ_W-1:0]             sa_ff, sa_in, sa_new;
   logic [css_pkg::SQ_W-1:0]             sb_ff, sb_in, sb_new;
   logic [css_pkg::CNT_W-1:0]            cnt_ff, cnt_in, cnt_new;
   logic signed [css_pkg::PROD_W-1:0]    pd_mul, pa_mul, pb_mul;
   logic                                 advance, accept, work, keep;
   css_pkg::status_type                  status;

   localparam logic [css_pkg::CNT_W-1:0] CNT_MAX = css_pkg::CNT_W'(css_pkg::MAX_LENGTH);

   assign advance  = !(stage_valid_ff && stage_last_ff && job_full);
   assign req_full = !advance;
   assign accept   = req_push && advance;
   assign work     = stage_valid_ff && advance;

   assign pd_mul = req_src_value * req_dst_value;
   assign pa_mul = req_src_value * req_src_value;
   assign pb_mul = req_dst_value * req_dst_value;

   always_comb begin
      cnt_new = (cnt_ff <= CNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;
      keep    = (cnt_new <= CNT_MAX);
      dot_new = keep ? dot_ff + css_pkg::DOT_W'(pd_ff) : dot_ff;
      sa_new  = keep ? sa_ff + css_pkg::SQ_W'(pa_ff) : sa_ff;
      sb_new  = keep ? sb_ff + css_pkg::SQ_W'(pb_ff) : sb_ff;
      if (!keep) begin
         status = css_pkg::STATUS_TOO_LONG;
      end else if (sa_new == '0 || sb_new == '0) begin
         status = css_pkg::STATUS_ZERO_NORM;
      end else begin
         status = css_pkg::STATUS_OK;
      end

      job_push        = work && stage_last_ff;
      job_data.dot    = dot_new;
      job_data.sum_a  = sa_new;
      job_data.sum_b  = sb_new;
      job_data.status = status;

      dot_in = dot_ff;
      sa_in  = sa_ff;
      sb_in  = sb_ff;
      cnt_in = cnt_ff;
      if (work) begin
         if (stage_last_ff) begin
            dot_in = '0;
            sa_in  = '0;
            sb_in  = '0;
            cnt_in = '0;
         end else begin
            dot_in = dot_new;
            sa_in  = sa_new;
            sb_in  = sb_new;
            cnt_in = cnt_new;
         end
      end

      stage_valid_in = stage_valid_ff;
      if (advance) begin
         stage_valid_in = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         dot_ff         <= '0;
         sa_ff          <= '0;
         sb_ff          <= '0;
         cnt_ff         <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         dot_ff         <= dot_in;
         sa_ff          <= sa_in;
         sb_ff          <= sb_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_last_ff <= req_last_element;
         pd_ff         <= pd_mul;
         pa_ff         <= pa_mul[css_pkg::SQ_PROD_W-1:0];
         pb_ff         <= pb_mul[css_pkg::SQ_PROD_W-1:0];
      end
   end

endmodule

/* sv/css_queue.sv */
// Short job queue between the front and back parts of the cosine
// similarity stream. Depends on css_pkg.
module css_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  css_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output css_pkg::job_type pop_data,
   output logic             empty
);

   localparam logic [css_pkg::QPTR_W-1:0] LAST_PTR = css_pkg::QPTR_W'(css_pkg::QUEUE_DEPTH - 1);

   css_pkg::job_type              mem [css_pkg::QUEUE_DEPTH];
   logic [css_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [css_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [css_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                          do_push, do_pop;

   assign full     = (count_ff == css_pkg::QCNT_W'(css_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/css_back.sv */
// Back part of the cosine similarity stream: serial multiply, restoring
// divide and digit-by-digit square root, then the result register.
// Depends on css_pkg.
module css_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             job_empty,
   input  css_pkg::job_type                 job_data,
   output logic                             job_pop,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic signed [css_pkg::SIM_W-1:0] rsp_similarity,
   output logic [1:0]                       rsp_status
);

   localparam int unsigned SQ_W   = css_pkg::SQ_W;
   localparam int unsigned WIDE_W = css_pkg::WIDE_W;
   localparam int unsigned QUO_W  = css_pkg::QUO_W;
   localparam int unsigned ROOT_W = css_pkg::ROOT_W;
   localparam int unsigned STEP_W = css_pkg::STEP_W;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_PREP = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_SQRT = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type                         state_ff, state_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic                              out_valid_ff, out_valid_in;
   logic                              neg_ff, neg_in;
   logic [1:0]                        status_ff, status_in;
   logic [WIDE_W-1:0]                 mcand_p_ff, mcand_p_in, prod_p_ff, prod_p_in;
   logic [WIDE_W-1:0]                 mcand_d_ff, mcand_d_in, prod_d_ff, prod_d_in;
   logic [SQ_W-1:0]                   mplier_p_ff, mplier_p_in, mplier_d_ff, mplier_d_in;
   logic [WIDE_W-1:0]                 rem_ff, rem_in;
   logic [QUO_W-1:0]                  nbits_ff, nbits_in, quo_ff, quo_in, quo_next;
   logic [QUO_W-1:0]                  num_ff, num_in, bit_ff, bit_in;
   logic [ROOT_W-1:0]                 root_ff, root_in, cand;
   logic [WIDE_W:0]                   trial, trial_diff;
   logic                              ge, fits, out_free;
   logic signed [css_pkg::DOT_W-1:0]  dot_neg;
   logic [SQ_W-1:0]                   dot_abs;
   logic signed [css_pkg::SIM_W-1:0]  sim_mag, sim_val;
   logic signed [css_pkg::SIM_W-1:0]  out_sim_ff;
   logic [1:0]                        out_status_ff;

   assign rsp_empty      = !out_valid_ff;
   assign rsp_similarity = out_sim_ff;
   assign rsp_status     = out_status_ff;

   always_comb begin
      dot_neg    = -job_data.dot;
      dot_abs    = job_data.dot[css_pkg::DOT_W-1] ? dot_neg[SQ_W-1:0]
                                                   : job_data.dot[SQ_W-1:0];
      trial      = {rem_ff, nbits_ff[QUO_W-1]};
      trial_diff = trial - {1'b0, prod_p_ff};
      ge         = (trial >= {1'b0, prod_p_ff});
      quo_next   = {quo_ff[QUO_W-2:0], ge};
      cand       = root_ff + {1'b0, bit_ff};
      fits       = ({1'b0, num_ff} >= cand);
      sim_mag    = css_pkg::SIM_W'(root_ff[css_pkg::FRAC_W:0]);
      sim_val    = neg_ff ? -sim_mag : sim_mag;
      out_free   = !out_valid_ff || rsp_pop;

      state_in    = state_ff;
      step_in     = step_ff;
      neg_in      = neg_ff;
      status_in   = status_ff;
      mcand_p_in  = mcand_p_ff;
      mplier_p_in = mplier_p_ff;
      prod_p_in   = prod_p_ff;
      mcand_d_in  = mcand_d_ff;
      mplier_d_in = mplier_d_ff;
      prod_d_in   = prod_d_ff;
      rem_in      = rem_ff;
      nbits_in    = nbits_ff;
      quo_in      = quo_ff;
      num_in      = num_ff;
      root_in     = root_ff;
      bit_in      = bit_ff;
      job_pop     = 1'b0;
      out_valid_in = (rsp_pop && out_valid_ff) ? 1'b0 : out_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop     = 1'b1;
               status_in   = job_data.status;
               neg_in      = job_data.dot[css_pkg::DOT_W-1];
               mcand_p_in  = WIDE_W'(job_data.sum_a);
               mplier_p_in = job_data.sum_b;
               prod_p_in   = '0;
               mcand_d_in  = WIDE_W'(dot_abs);
               mplier_d_in = dot_abs;
               prod_d_in   = '0;
               root_in     = '0;
               step_in     = '0;
               state_in    = (job_data.status == css_pkg::STATUS_OK) ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            if (mplier_p_ff[0]) begin
               prod_p_in = prod_p_ff + mcand_p_ff;
            end
            if (mplier_d_ff[0]) begin
               prod_d_in = prod_d_ff + mcand_d_ff;
            end
            mcand_p_in  = mcand_p_ff << 1;
            mcand_d_in  = mcand_d_ff << 1;
            mplier_p_in = mplier_p_ff >> 1;
            mplier_d_in = mplier_d_ff >> 1;
            step_in     = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQ_W - 1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            rem_in   = prod_d_ff >> 1;
            nbits_in = {prod_d_ff[0], {(QUO_W-1){1'b0}}};
            quo_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in   = ge ? trial_diff[WIDE_W-1:0] : trial[WIDE_W-1:0];
            nbits_in = nbits_ff << 1;
            quo_in   = quo_next;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               num_in   = quo_next;
               root_in  = '0;
               bit_in   = {1'b1, {(QUO_W-1){1'b0}}};
               step_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (fits) begin
               num_in  = num_ff - cand[QUO_W-1:0];
               root_in = (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(css_pkg::ROOT_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      neg_ff      <= neg_in;
      status_ff   <= status_in;
      mcand_p_ff  <= mcand_p_in;
      mplier_p_ff <= mplier_p_in;
      prod_p_ff   <= prod_p_in;
      mcand_d_ff  <= mcand_d_in;
      mplier_d_ff <= mplier_d_in;
      prod_d_ff   <= prod_d_in;
      rem_ff      <= rem_in;
      nbits_ff    <= nbits_in;
      quo_ff      <= quo_in;
      num_ff      <= num_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      if (state_ff == ST_DONE && out_free) begin
         out_sim_ff    <= (status_ff == css_pkg::STATUS_OK) ? sim_val : '0;
         out_status_ff <= status_ff;
      end
   end

endmodule

/* sv/cosine_similarity_stream.sv */
// Top level of the cosine similarity stream: front accumulator, job queue
// and back divider/root unit. Depends on css_pkg, css_front, css_queue, css_back.
//
// Usage: push one element pair per cycle on req_src_value / req_dst_value
// while req_full is low; mark the final pair of a vector with req_last_element.
// Each marked pair yields one result on rsp_similarity (signed Q1.16, truncated
// toward zero) and rsp_status (0 ok, 1 zero norm, 2 longer than MAX_LENGTH).
// A result is valid while rsp_empty is low and transfers when rsp_pop is high.
// Throughput: one element pair per cycle while req_full is low; the front
// multiply-accumulate stage sets that rate. Per vector the back unit runs
// SQ_W serial multiply steps, 33 divide steps and 17 root steps plus hand-off,
// or only the hand-off when the status is nonzero, so vectors shorter than
// that work make req_full rise once the two-entry job queue is full.
// Reset (synchronous, active high) clears the accumulators, queue and result valid
// flag. When rsp_pop stays low the finished result holds, the back unit waits in
// its final step and the front accumulates until a last pair meets a full queue.
module cosine_similarity_stream (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [css_pkg::ELEM_W-1:0]  req_src_value,
   input  logic signed [css_pkg::ELEM_W-1:0]  req_dst_value,
   input  logic                               req_last_element,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [css_pkg::SIM_W-1:0]   rsp_similarity,
   output logic [1:0]                         rsp_status
);

   logic             job_push, job_full, job_pop, job_empty;
   css_pkg::job_type job_in, job_out;

   css_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_src_value    (req_src_value),
      .req_dst_value    (req_dst_value),
      .req_last_element (req_last_element),
      .job_push         (job_push),
      .job_data         (job_in),
      .job_full         (job_full)
   );

   css_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty)
   );

   css_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_empty      (job_empty),
      .job_data       (job_out),
      .job_pop        (job_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_similarity (rsp_similarity),
      .rsp_status     (rsp_status)
   );

   a_job_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("job pushed into a full queue");

   a_job_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty)
      else $error("job popped from an empty queue");

   a_bad_status_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != css_pkg::STATUS_OK) |-> rsp_similarity == '0)
      else $error("nonzero status with nonzero similarity");

   a_sim_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_similarity <= 18'sd65536 && rsp_similarity >= -18'sd65536))
      else $error("similarity out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result visible after reset");

endmodule

/* sim/tb.sv */
// Testbench for cosine_similarity_stream: drives element pairs through the queue-style
// ports, predicts each vector's Q1.16 similarity and status, and checks every transfer.
// Depends on css_pkg and the cosine_similarity_stream RTL.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned CYCLE_LIMIT  = 2000000;
   localparam int unsigned HOLD_CYCLES  = 1500;
   localparam int unsigned DRAIN_CYCLES = 300;

   typedef logic [191:0] wide_type;

   typedef enum int {
      PHASE_STEADY,
      PHASE_SPARSE_SEND,
      PHASE_SLOW_DRAIN,
      PHASE_MIXED,
      PHASE_BACKPRESSURE
   } phase_type;

   typedef enum int {
      MIX_FULL,
      MIX_SMALL,
      MIX_EXTREME,
      MIX_MATCHED,
      MIX_OPPOSED
   } value_mix_type;

   typedef struct {
      logic signed [css_pkg::ELEM_W-1:0] src;
      logic signed [css_pkg::ELEM_W-1:0] dst;
      logic                              last;
   } element_pair_type;

   typedef struct {
      logic signed [css_pkg::SIM_W-1:0] similarity;
      css_pkg::status_type              status;
   } cosine_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [css_pkg::ELEM_W-1:0] req_src_value = '0;
   logic signed [css_pkg::ELEM_W-1:0] req_dst_value = '0;
   logic req_last_element = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [css_pkg::SIM_W-1:0] rsp_similarity;
   logic [1:0] rsp_status;

   element_pair_type  pending_pairs[$];
   cosine_result_type expected_results[$];

   logic signed [css_pkg::DOT_W-1:0] dot_total = '0;
   logic [css_pkg::SQ_W-1:0]         src_energy = '0;
   logic [css_pkg::SQ_W-1:0]         dst_energy = '0;
   logic [css_pkg::CNT_W-1:0]        pairs_seen = '0;

   phase_type   phase = PHASE_STEADY;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_count = 0;
   logic        hold_done = 1'b0;
   logic        holding;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;

   cosine_similarity_stream DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_src_value    (req_src_value),
      .req_dst_value    (req_dst_value),
      .req_last_element (req_last_element),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_similarity   (rsp_similarity),
      .rsp_status       (rsp_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // largest q in 0..65536 with q*q*sa*sb <= mag*mag*2^32
   function automatic int unsigned cosine_q16(longint unsigned mag, wide_type sa,
                                              wide_type sb);
      wide_type target;
      wide_type norm_product;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      target = (wide_type'(mag) * wide_type'(mag)) << 32;
      norm_product = sa * sb;
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (wide_type'(mid) * wide_type'(mid) * norm_product <= target)
            lo = mid;
         else
            hi = mid - 1;
      end
      return lo;
   endfunction

   task automatic absorb_pair(element_pair_type pair);
      int a;
      int b;
      int unsigned a_sq;
      int unsigned b_sq;
      longint dot_wide;
      longint unsigned mag;
      int q;
      cosine_result_type outcome;
      a = pair.src;
      b = pair.dst;
      a_sq = a * a;
      b_sq = b * b;
      if (pairs_seen <= css_pkg::MAX_LENGTH)
         pairs_seen = pairs_seen + 1'b1;
      if (pairs_seen <= css_pkg::MAX_LENGTH) begin
         dot_total = dot_total + a * b;
         src_energy = src_energy + a_sq;
         dst_energy = dst_energy + b_sq;
      end
      if (pair.last) begin
         outcome.similarity = '0;
         outcome.status = css_pkg::STATUS_OK;
         if (pairs_seen > css_pkg::MAX_LENGTH) begin
            outcome.status = css_pkg::STATUS_TOO_LONG;
         end else if (src_energy == 0 || dst_energy == 0) begin
            outcome.status = css_pkg::STATUS_ZERO_NORM;
         end else begin
            dot_wide = dot_total;
            mag = (dot_wide < 0) ? -dot_wide : dot_wide;
            q = cosine_q16(mag, src_energy, dst_energy);
            outcome.similarity = (dot_wide < 0) ? -q : q;
         end
         expected_results.insert(expected_results.size(), outcome);
         dot_total = '0;
         src_energy = '0;
         dst_energy = '0;
         pairs_seen = '0;
      end
   endtask

   always @(posedge clock) begin : driver
      logic accepted;
      accepted = req_push && !req_full;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (accepted) begin
            absorb_pair(pending_pairs.pop_front());
         end
         if (req_push && !accepted) begin
            // hold the offered pair until it transfers
         end else if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_push <= 1'b1;
            req_src_value <= pending_pairs[0].src;
            req_dst_value <= pending_pairs[0].dst;
            req_last_element <= pending_pairs[0].last;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_count <= 0;
         hold_done <= 1'b0;
      end else if (holding) begin
         if (hold_count == HOLD_CYCLES - 1)
            hold_done <= 1'b1;
         hold_count <= hold_count + 1;
      end
   end

   assign holding = (phase == PHASE_BACKPRESSURE) && !hold_done;

   always @(posedge clock) begin : monitor
      cosine_result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: similarity %0d status %0d",
                      rsp_similarity, rsp_status);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_similarity !== want.similarity) begin
                  $error("similarity expected %0d actual %0d", want.similarity,
                         rsp_similarity);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  error_count++;
               end
            end
         end
         rsp_pop <= !holding && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic add_pair(int src, int dst, logic last);
      element_pair_type pair;
      pair.src = src[css_pkg::ELEM_W-1:0];
      pair.dst = dst[css_pkg::ELEM_W-1:0];
      pair.last = last;
      pending_pairs.insert(pending_pairs.size(), pair);
   endtask

   function automatic int pick_value(value_mix_type mix);
      int v;
      case (mix)
         MIX_SMALL: v = int'($urandom_range(0, 16)) - 8;
         MIX_EXTREME: begin
            case ($urandom_range(0, 4))
               0: v = -32768;
               1: v = 32767;
               2: v = -1;
               3: v = 0;
               default: v = 1;
            endcase
         end
         default: v = int'($urandom_range(0, 65535)) - 32768;
      endcase
      return v;
   endfunction

   task automatic add_vector(int length);
      value_mix_type mix;
      int zero_side;
      int src;
      int dst;
      mix = value_mix_type'($urandom_range(0, 4));
      zero_side = ($urandom_range(0, 11) == 0) ? int'($urandom_range(1, 2)) : 0;
      for (int i = 0; i < length; i++) begin
         src = pick_value(mix);
         case (mix)
            MIX_MATCHED: dst = src + (($urandom_range(0, 3) == 0) ? pick_value(MIX_SMALL) : 0);
            MIX_OPPOSED: dst = -src;
            default: dst = pick_value(mix);
         endcase
         if (zero_side == 1)
            src = 0;
         if (zero_side == 2)
            dst = 0;
         add_pair(src, dst, i == length - 1);
      end
   endtask

   task automatic run_phase(phase_type p, int unsigned send_pct, int unsigned recv_pct,
                            int item_goal, int max_len);
      int placed;
      int length;
      phase = p;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      placed = 0;
      while (placed < item_goal) begin
         if (max_len <= 8 || $urandom_range(0, 99) < 85)
            length = $urandom_range(1, (max_len < 8) ? max_len : 8);
         else
            length = $urandom_range(9, max_len);
         add_vector(length);
         placed += length;
      end
      while (pending_pairs.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      add_pair(1, 1, 1'b1);
      add_pair(-32768, 32767, 1'b1);
      add_pair(-32768, -32768, 1'b1);
      add_pair(32767, 32767, 1'b1);
      add_pair(0, 5, 1'b1);
      add_pair(7, 0, 1'b1);
      add_pair(0, 0, 1'b1);
      add_pair(1, 0, 1'b0);
      add_pair(0, 1, 1'b1);
      add_pair(21845, -21846, 1'b0);
      add_pair(-21846, 21845, 1'b1);
      add_pair(1, 2, 1'b0);
      add_pair(3, -4, 1'b0);
      add_pair(-5, 6, 1'b1);
      add_pair(32767, -32768, 1'b0);
      add_pair(-32768, 32767, 1'b1);
      add_pair(-1, -1, 1'b0);
      add_pair(0, 0, 1'b1);
      add_pair(0, 3, 1'b0);
      add_pair(0, -3, 1'b1);

      run_phase(PHASE_STEADY, 0, 0, 250, 48);
      run_phase(PHASE_SPARSE_SEND, 86, 0, 250, 48);
      run_phase(PHASE_SLOW_DRAIN, 0, 86, 250, 48);
      run_phase(PHASE_MIXED, 16, 16, 250, 48);
      run_phase(PHASE_BACKPRESSURE, 0, 0, 150, 2);

      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/css_pkg.sv
sv/css_front.sv
sv/css_queue.sv
sv/css_back.sv
sv/cosine_similarity_stream.sv
sim/tb.sv
